>>> sv/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared types and constants of the 8-bit hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // full scale of every 8-bit channel
    localparam logic [7:0]  FULL_SCALE   = 8'd255;

    // divisor of the level numerators (255 * 255) and its round-up offset
    localparam logic [23:0] DIV_SCALE    = 24'd65025;
    localparam logic [23:0] DIV_ROUND_UP = 24'd65024;

    // raw sector reached only by the top hue code, folds back to sector zero
    localparam logic [2:0]  SECTOR_WRAP  = 3'd6;

    // hexcone sectors, named by the hue span they cover
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

`default_nettype wire

>>> sv/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// 8-bit hsv to 8-bit rgb pixel converter, five-stage pipeline
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock when the output side is not stalled and
// returns its rgb beat after the five register stages (hue decode and v*s
// product, level numerators, reciprocal estimate, remainder correction, level
// select). Each stage holds its own valid bit, so a stall on the output only
// stops the stages behind an occupied one and bubbles are squeezed out. Levels
// are exact and truncated: top is value, bottom is floor(v - v*s/255), middle
// is floor(v - v*s*g/65025), g = 255-f in even sectors and f in odd ones.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // hue[7:0], saturation[15:8], value[23:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    stage_en_t   en;
    logic [4:0]  valid_reg;
    logic [4:0]  valid_next;

    logic [23:0] x_mid;
    logic [23:0] x_bot;
    logic [7:0]  v2;
    sector_t     sec2;
    logic [7:0]  q_mid;
    logic [7:0]  q_bot;

    logic [7:0]  v3_reg;
    sector_t     sec3_reg;
    logic [7:0]  v4_reg;
    sector_t     sec4_reg;

    logic [7:0]  mid_w;
    logic [7:0]  bot_w;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    // a stage loads when empty or when the stage after it moves
    always_comb begin
        en.s5 = !valid_reg[4] || m_axis_tready;
        en.s4 = !valid_reg[3] || en.s5;
        en.s3 = !valid_reg[2] || en.s4;
        en.s2 = !valid_reg[1] || en.s3;
        en.s1 = !valid_reg[0] || en.s2;
    end

    assign s_axis_tready = en.s1;

    // valid bits travel with the data
    always_comb begin
        valid_next = valid_reg;
        if (en.s1) begin
            valid_next[0] = s_axis_tvalid;
        end
        if (en.s2) begin
            valid_next[1] = valid_reg[0];
        end
        if (en.s3) begin
            valid_next[2] = valid_reg[1];
        end
        if (en.s4) begin
            valid_next[3] = valid_reg[2];
        end
        if (en.s5) begin
            valid_next[4] = valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // sector decode and level numerators
    hsvrgb_front u_front (
        .aclk       (aclk),
        .en         (en),
        .hue        (s_axis_tdata[7:0]),
        .saturation (s_axis_tdata[15:8]),
        .value      (s_axis_tdata[23:16]),
        .x_mid      (x_mid),
        .x_bot      (x_bot),
        .value_out  (v2),
        .sector_out (sec2)
    );

    // ceiling divides for middle and bottom levels
    hsvrgb_div u_div_mid (
        .aclk     (aclk),
        .en       (en),
        .x        (x_mid),
        .quotient (q_mid)
    );

    hsvrgb_div u_div_bot (
        .aclk     (aclk),
        .en       (en),
        .x        (x_bot),
        .quotient (q_bot)
    );

    // value and sector ride along the divide stages
    always_ff @(posedge aclk) begin
        if (en.s3) begin
            v3_reg   <= v2;
            sec3_reg <= sec2;
        end
        if (en.s4) begin
            v4_reg   <= v3_reg;
            sec4_reg <= sec3_reg;
        end
    end

    // levels and hexcone channel select
    always_comb begin
        mid_w = v4_reg - q_mid;
        bot_w = v4_reg - q_bot;
        case (sec4_reg)
            SEC_R_TO_Y: begin
                red_next = v4_reg; green_next = mid_w;  blue_next = bot_w;
            end
            SEC_Y_TO_G: begin
                red_next = mid_w;  green_next = v4_reg; blue_next = bot_w;
            end
            SEC_G_TO_C: begin
                red_next = bot_w;  green_next = v4_reg; blue_next = mid_w;
            end
            SEC_C_TO_B: begin
                red_next = bot_w;  green_next = mid_w;  blue_next = v4_reg;
            end
            SEC_B_TO_M: begin
                red_next = mid_w;  green_next = bot_w;  blue_next = v4_reg;
            end
            default: begin
                red_next = v4_reg; green_next = bot_w;  blue_next = mid_w;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en.s5) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_axis_tvalid = valid_reg[4];
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

endmodule

`default_nettype wire

>>> sv/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// hsvrgb_front
// stages one and two: hue sector decode, v*s product and level numerators
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  wire logic       aclk,
    input  wire stage_en_t  en,
    input  wire logic [7:0] hue,
    input  wire logic [7:0] saturation,
    input  wire logic [7:0] value,
    output logic [23:0]     x_mid,
    output logic [23:0]     x_bot,
    output logic [7:0]      value_out,
    output sector_t         sector_out
);

    logic [10:0] t_w;
    logic [2:0]  raw_sec_w;
    logic [10:0] frac_w;
    logic [7:0]  frac8_w;
    sector_t     sector_w;
    logic [7:0]  g_next;
    logic [15:0] vs_next;

    logic [15:0] vs_reg;
    logic [7:0]  g_reg;
    logic [7:0]  v1_reg;
    sector_t     sec1_reg;

    logic [23:0] p_w;
    logic [23:0] xmid_next;
    logic [23:0] xbot_next;
    logic [23:0] xmid_reg;
    logic [23:0] xbot_reg;
    logic [7:0]  v2_reg;
    sector_t     sec2_reg;

    // hue times six, then sector by threshold compare
    always_comb begin
        t_w = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        if (t_w >= 11'd1530) begin
            raw_sec_w = SECTOR_WRAP;
        end else if (t_w >= 11'd1275) begin
            raw_sec_w = SEC_M_TO_R;
        end else if (t_w >= 11'd1020) begin
            raw_sec_w = SEC_B_TO_M;
        end else if (t_w >= 11'd765) begin
            raw_sec_w = SEC_C_TO_B;
        end else if (t_w >= 11'd510) begin
            raw_sec_w = SEC_G_TO_C;
        end else if (t_w >= 11'd255) begin
            raw_sec_w = SEC_Y_TO_G;
        end else begin
            raw_sec_w = SEC_R_TO_Y;
        end
    end

    // fraction inside the sector, wrap and mirror
    always_comb begin
        frac_w  = t_w - ({raw_sec_w, 8'd0} - {8'd0, raw_sec_w});
        frac8_w = frac_w[7:0];
        if (raw_sec_w == SECTOR_WRAP) begin
            sector_w = SEC_R_TO_Y;
        end else begin
            sector_w = sector_t'(raw_sec_w);
        end
        // distance of the middle level below top, in 1/255 steps
        if (sector_w[0]) begin
            g_next = frac8_w;
        end else begin
            g_next = FULL_SCALE - frac8_w;
        end
        vs_next = {8'd0, value} * {8'd0, saturation};
    end

    // stage one registers
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            vs_reg   <= vs_next;
            g_reg    <= g_next;
            v1_reg   <= value;
            sec1_reg <= sector_w;
        end
    end

    // numerators with round-up offset for the ceiling divide
    always_comb begin
        p_w       = {8'd0, vs_reg} * {16'd0, g_reg};
        xmid_next = p_w + DIV_ROUND_UP;
        xbot_next = {vs_reg, 8'd0} - {8'd0, vs_reg} + DIV_ROUND_UP;
    end

    // stage two registers
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            xmid_reg <= xmid_next;
            xbot_reg <= xbot_next;
            v2_reg   <= v1_reg;
            sec2_reg <= sec1_reg;
        end
    end

    assign x_mid      = xmid_reg;
    assign x_bot      = xbot_reg;
    assign value_out  = v2_reg;
    assign sector_out = sec2_reg;

endmodule

`default_nettype wire

>>> sv/hsvrgb_div.sv
// ----------------------------------------------------------------------------
// hsvrgb_div
// two-stage divide by 65025: reciprocal estimate, then one-step correction
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_div
    import hsvrgb_pkg::*;
(
    input  wire logic        aclk,
    input  wire stage_en_t   en,
    input  wire logic [23:0] x,
    output logic [7:0]       quotient
);

    logic [31:0] prod_w;
    logic [7:0]  q0_next;
    logic [7:0]  q0_reg;
    logic [23:0] x3_reg;

    logic [23:0] back_w;
    logic [23:0] rem_w;
    logic [7:0]  q_next;
    logic [7:0]  q_reg;

    // estimate: x * 258 / 2^24, low by at most one
    always_comb begin
        prod_w  = {x, 8'd0} + {7'd0, x, 1'b0};
        q0_next = prod_w[31:24];
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            q0_reg <= q0_next;
            x3_reg <= x;
        end
    end

    // remainder check: q0 * 65025 as shift-add, bump when a divisor is left
    always_comb begin
        back_w = {q0_reg, 16'd0} - {7'd0, q0_reg, 9'd0} + {16'd0, q0_reg};
        rem_w  = x3_reg - back_w;
        if (rem_w >= DIV_SCALE) begin
            q_next = q0_reg + 8'd1;
        end else begin
            q_next = q0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            q_reg <= q_next;
        end
    end

    assign quotient = q_reg;

endmodule

`default_nettype wire
